FILE: rtl/core/swpt_pkg.sv
// ----------------------------------------------------------------------------
// swpt_pkg
// Shared widths, codes and controller/datapath handshake types for the step
// waveform pattern table.
// ----------------------------------------------------------------------------
package swpt_pkg;

  // default sizing of the table
  localparam int NUM_RULES_DEF  = 8;
  localparam int MAX_POINTS_DEF = 16;
  localparam int VALUE_BITS_DEF = 32;

  // fixed field widths
  localparam int KIND_W   = 2;
  localparam int ID_W     = 4;
  localparam int SECS_W   = 31;
  localparam int PERIOD_W = SECS_W + 1;
  localparam int SAMPLE_W = 32;
  localparam int STATUS_W = 2;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CHECK = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;       // latch the accepted request
    logic classify;   // decode request, open a rule, read per-rule memories
    logic add_exec;   // store one point of the open rule
    logic add_close;  // write back time-zero point, period and count
    logic div_start;  // start time modulo period
    logic scan_init;  // reset the point scan
    logic scan_step;  // advance the point scan
    logic scan_fin;   // stage query result
    logic check;      // compare and update remembered value
    logic emit;       // move staged result to the output register
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              early;      // result already known after decode
    logic              last;       // request closes the open rule
    logic              div_busy;
    logic              scan_done;
    logic              out_free;   // output register can take a result
  } flags_t;

endpackage

FILE: rtl/core/swpt_if.sv
// ----------------------------------------------------------------------------
// swpt_if
// Valid/ready channels: request channel and result channel.
// ----------------------------------------------------------------------------
interface swpt_req_if;
  logic                                valid;
  logic                                ready;
  logic [swpt_pkg::KIND_W-1:0]         kind;
  logic [swpt_pkg::ID_W-1:0]           rule_id;
  logic [swpt_pkg::SECS_W-1:0]         seconds;
  logic signed [swpt_pkg::SAMPLE_W-1:0] sample;
  logic                                last_point;

  modport source (output valid, kind, rule_id, seconds, sample, last_point, input ready);
  modport sink   (input valid, kind, rule_id, seconds, sample, last_point, output ready);
endinterface

interface swpt_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [swpt_pkg::SAMPLE_W-1:0] result_value;
  logic [swpt_pkg::ID_W-1:0]            rule_number;
  logic                                 changed;
  logic [swpt_pkg::STATUS_W-1:0]        status;

  modport source (output valid, result_value, rule_number, changed, status, input ready);
  modport sink   (input valid, result_value, rule_number, changed, status, output ready);
endinterface

FILE: rtl/core/swpt_mod.sv
// ----------------------------------------------------------------------------
// swpt_mod
// Bit-serial restoring remainder: elapsed time modulo rule period, one
// dividend bit per cycle.
// ----------------------------------------------------------------------------
module swpt_mod (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [swpt_pkg::SECS_W-1:0]     dividend,
  input  logic [swpt_pkg::PERIOD_W-1:0]   divisor,
  output logic                            busy,
  output logic [swpt_pkg::PERIOD_W-1:0]   remainder
);

  localparam int CNT_W = $clog2(swpt_pkg::SECS_W);

  logic [CNT_W-1:0]                cnt;
  logic [swpt_pkg::SECS_W-1:0]     dvd;
  logic [swpt_pkg::PERIOD_W-1:0]   dsr;
  logic [swpt_pkg::PERIOD_W-1:0]   rem;
  logic [swpt_pkg::PERIOD_W-1:0]   trial;

  // remainder stays below the divisor, so its top bit is always clear
  assign trial     = {rem[swpt_pkg::PERIOD_W-2:0], dvd[swpt_pkg::SECS_W-1]};
  assign remainder = rem;

  // step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == '0) begin
      busy <= 1'b0;
    end
  end

  // shift/subtract datapath
  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= CNT_W'(swpt_pkg::SECS_W - 1);
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      dvd <= {dvd[swpt_pkg::SECS_W-2:0], 1'b0};
      rem <= (trial >= dsr) ? trial - dsr : trial;
    end
  end

endmodule

FILE: rtl/core/swpt_dp.sv
// ----------------------------------------------------------------------------
// swpt_dp
// Datapath: request latch, rule/point memories, open-rule registers,
// remainder unit, point scan and result registers.
// ----------------------------------------------------------------------------
module swpt_dp #(
  parameter int NUM_RULES  = swpt_pkg::NUM_RULES_DEF,
  parameter int MAX_POINTS = swpt_pkg::MAX_POINTS_DEF,
  parameter int VALUE_BITS = swpt_pkg::VALUE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  swpt_pkg::cmd_t                       cmd,
  output swpt_pkg::flags_t                     flags,
  input  logic [swpt_pkg::KIND_W-1:0]          kind,
  input  logic [swpt_pkg::ID_W-1:0]            rule_id,
  input  logic [swpt_pkg::SECS_W-1:0]          seconds,
  input  logic signed [swpt_pkg::SAMPLE_W-1:0] sample,
  input  logic                                 last_point,
  output logic signed [swpt_pkg::SAMPLE_W-1:0] result_value,
  output logic [swpt_pkg::ID_W-1:0]            rule_number,
  output logic                                 changed,
  output logic [swpt_pkg::STATUS_W-1:0]        status,
  output logic                                 res_valid,
  input  logic                                 res_ready
);

  localparam int RW    = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;
  localparam int PW    = $clog2(MAX_POINTS);
  localparam int CW    = $clog2(MAX_POINTS + 1);
  localparam int DW    = $clog2(NUM_RULES + 1);
  localparam int CMPW  = (DW > swpt_pkg::ID_W) ? DW : swpt_pkg::ID_W;
  localparam int RULES = 1 << RW;
  localparam int SLOTS = RULES << PW;

  // latched request
  logic [swpt_pkg::KIND_W-1:0]  kind_q;
  logic [swpt_pkg::ID_W-1:0]    id_q;
  logic [swpt_pkg::SECS_W-1:0]  secs_q;
  logic [VALUE_BITS-1:0]        val_q;
  logic                         last_q;

  // table state
  logic [DW-1:0]                rules_defined;
  logic                         rule_open;
  logic [CW-1:0]                cur_count;
  logic [swpt_pkg::PERIOD_W-1:0] cur_period;
  logic [VALUE_BITS-1:0]        cur_v0;

  // memories
  logic [swpt_pkg::SECS_W-1:0]   pt_time_mem [SLOTS];
  logic [VALUE_BITS-1:0]         pt_val_mem  [SLOTS];
  logic [swpt_pkg::PERIOD_W-1:0] per_mem     [RULES];
  logic [CW-1:0]                 cnt_mem     [RULES];
  logic [VALUE_BITS-1:0]         rem_mem     [RULES];
  logic [RULES-1:0]              rem_vld;

  logic [swpt_pkg::SECS_W-1:0]   pt_rd_time;
  logic [VALUE_BITS-1:0]         pt_rd_val;
  logic [swpt_pkg::PERIOD_W-1:0] per_rd;
  logic [CW-1:0]                 cnt_rd;
  logic [VALUE_BITS-1:0]         rem_rd;
  logic                          rem_rd_vld;

  // scan state
  logic [CW-1:0]                 iss_idx;
  logic                          pend;
  logic                          stop;
  logic [VALUE_BITS-1:0]         scan_v;

  // staged result
  logic signed [swpt_pkg::SAMPLE_W-1:0] st_value;
  logic [swpt_pkg::ID_W-1:0]            st_rn;
  logic                                 st_ch;
  logic [swpt_pkg::STATUS_W-1:0]        st_st;

  // derived signals
  logic [DW-1:0]                 closed;
  logic                          known;
  logic                          table_full;
  logic [swpt_pkg::ID_W-1:0]     id_m1;
  logic [RW-1:0]                 rd_rule;
  logic [RW-1:0]                 cur_rule;
  logic                          append;
  logic                          pt_we;
  logic [RW+PW-1:0]              pt_wa;
  logic [swpt_pkg::SECS_W-1:0]   pt_wt;
  logic [VALUE_BITS-1:0]         pt_wv;
  logic                          pt_re;
  logic [RW+PW-1:0]              pt_ra;
  logic [VALUE_BITS-1:0]         stored;
  logic                          div_busy;
  logic [swpt_pkg::PERIOD_W-1:0] t_mod;
  logic [swpt_pkg::PERIOD_W-1:0] divisor;

  // rule lookup
  assign closed     = rules_defined - DW'(rule_open);
  assign known      = (id_q != '0) && (CMPW'(id_q) <= CMPW'(closed));
  assign table_full = !rule_open && (rules_defined >= DW'(NUM_RULES));
  assign id_m1      = id_q - swpt_pkg::ID_W'(1);
  assign rd_rule    = RW'(id_m1);
  assign cur_rule   = RW'(rules_defined - DW'(1));
  assign stored     = rem_rd_vld ? rem_rd : '1;

  // point memory write port
  assign append = cmd.add_exec && (secs_q != '0) && (cur_count < CW'(MAX_POINTS));
  assign pt_we  = append || cmd.add_close;
  assign pt_wa  = cmd.add_close ? {cur_rule, PW'(0)} : {cur_rule, cur_count[PW-1:0]};
  assign pt_wt  = cmd.add_close ? '0 : secs_q;
  assign pt_wv  = cmd.add_close ? cur_v0 : val_q;

  // point memory read port, used by the scan only
  assign pt_re = cmd.scan_step && !stop && (iss_idx < cnt_rd);
  assign pt_ra = {rd_rule, iss_idx[PW-1:0]};

  always_ff @(posedge clk) begin
    if (pt_we) begin
      pt_time_mem[pt_wa] <= pt_wt;
      pt_val_mem[pt_wa]  <= pt_wv;
    end
    if (pt_re) begin
      pt_rd_time <= pt_time_mem[pt_ra];
      pt_rd_val  <= pt_val_mem[pt_ra];
    end
  end

  // per-rule memories
  always_ff @(posedge clk) begin
    if (cmd.add_close) begin
      per_mem[cur_rule] <= cur_period;
      cnt_mem[cur_rule] <= cur_count;
    end
    if (cmd.check && stored != val_q) begin
      rem_mem[rd_rule] <= val_q;
    end
    if (cmd.classify) begin
      per_rd     <= per_mem[rd_rule];
      cnt_rd     <= cnt_mem[rd_rule];
      rem_rd     <= rem_mem[rd_rule];
      rem_rd_vld <= rem_vld[rd_rule];
    end
  end

  // remembered-value valid bits: an unwritten entry reads as minus one
  always_ff @(posedge clk) begin
    if (rst) begin
      rem_vld <= '0;
    end else if (cmd.check && stored != val_q) begin
      rem_vld[rd_rule] <= 1'b1;
    end
  end

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q <= kind;
      id_q   <= rule_id;
      secs_q <= seconds;
      val_q  <= sample[VALUE_BITS-1:0];
      last_q <= last_point;
    end
  end

  // rule count and open flag
  always_ff @(posedge clk) begin
    if (rst) begin
      rules_defined <= '0;
      rule_open     <= 1'b0;
    end else if (cmd.classify && kind_q == swpt_pkg::KIND_ADD && !rule_open && !table_full) begin
      rules_defined <= rules_defined + DW'(1);
      rule_open     <= 1'b1;
    end else if (cmd.add_exec && last_q) begin
      rule_open     <= 1'b0;
    end
  end

  // open-rule registers
  always_ff @(posedge clk) begin
    if (cmd.classify && kind_q == swpt_pkg::KIND_ADD && !rule_open) begin
      cur_count  <= CW'(1);
      cur_period <= swpt_pkg::PERIOD_W'(1);
      cur_v0     <= '1;
    end else if (cmd.add_exec) begin
      if (secs_q == '0) begin
        cur_v0     <= val_q;
        cur_period <= swpt_pkg::PERIOD_W'(1);
      end else if (append) begin
        cur_count  <= cur_count + CW'(1);
        cur_v0     <= val_q;
        cur_period <= swpt_pkg::PERIOD_W'(secs_q) + swpt_pkg::PERIOD_W'(1);
      end
    end
  end

  // time modulo period
  assign divisor = (per_rd == '0) ? swpt_pkg::PERIOD_W'(1) : per_rd;

  swpt_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (secs_q),
    .divisor   (divisor),
    .busy      (div_busy),
    .remainder (t_mod)
  );

  // point scan: one read issued per cycle, compared the cycle after
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      stop <= 1'b0;
    end else if (cmd.scan_init) begin
      pend <= 1'b0;
      stop <= 1'b0;
    end else if (cmd.scan_step) begin
      pend <= pt_re;
      if (pend && !stop && swpt_pkg::PERIOD_W'(pt_rd_time) > t_mod) begin
        stop <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      iss_idx <= '0;
      scan_v  <= '0;
    end else if (cmd.scan_step) begin
      if (pt_re) begin
        iss_idx <= iss_idx + CW'(1);
      end
      if (pend && !stop && swpt_pkg::PERIOD_W'(pt_rd_time) <= t_mod) begin
        scan_v <= pt_rd_val;
      end
    end
  end

  // staged result
  always_ff @(posedge clk) begin
    if (cmd.classify) begin
      st_value <= '0;
      st_rn    <= '0;
      st_ch    <= 1'b0;
      st_st    <= swpt_pkg::ST_DONE;
      priority if (kind_q == swpt_pkg::KIND_ADD) begin
        if (table_full) begin
          st_st <= swpt_pkg::ST_FULL;
        end
      end else if (kind_q == swpt_pkg::KIND_QUERY) begin
        st_value <= '1;
        st_st    <= swpt_pkg::ST_NOT_FOUND;
      end else if (kind_q == swpt_pkg::KIND_CHECK) begin
        if (rules_defined == '0) begin
          st_ch <= 1'b1;
        end else begin
          st_value <= '1;
          st_st    <= swpt_pkg::ST_NOT_FOUND;
        end
      end else begin
        st_st <= swpt_pkg::ST_DONE;
      end
    end else if (cmd.add_exec) begin
      st_value <= '0;
      st_rn    <= swpt_pkg::ID_W'(rules_defined);
      st_ch    <= 1'b0;
      st_st    <= (secs_q != '0 && !append) ? swpt_pkg::ST_FULL : swpt_pkg::ST_DONE;
    end else if (cmd.scan_fin) begin
      st_value <= swpt_pkg::SAMPLE_W'($signed(scan_v));
      st_rn    <= id_q;
      st_ch    <= 1'b0;
      st_st    <= swpt_pkg::ST_DONE;
    end else if (cmd.check) begin
      st_value <= '0;
      st_rn    <= id_q;
      st_ch    <= (stored != val_q);
      st_st    <= swpt_pkg::ST_DONE;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result_value <= st_value;
      rule_number  <= st_rn;
      changed      <= st_ch;
      status       <= st_st;
    end
  end

  // status to the controller
  always_comb begin
    flags.kind      = kind_q;
    flags.last      = last_q;
    flags.div_busy  = div_busy;
    flags.scan_done = stop || (!pend && iss_idx == cnt_rd);
    flags.out_free  = !res_valid || res_ready;
    unique case (kind_q)
      swpt_pkg::KIND_ADD:   flags.early = table_full;
      swpt_pkg::KIND_QUERY: flags.early = !known;
      swpt_pkg::KIND_CHECK: flags.early = (rules_defined == '0) || !known;
      default:              flags.early = 1'b1;
    endcase
  end

  // checks
  a_open_has_rule: assert property (@(posedge clk) disable iff (rst)
    rule_open |-> rules_defined != '0)
    else $error("open rule without a defined rule");

  a_rule_limit: assert property (@(posedge clk) disable iff (rst)
    rules_defined <= DW'(NUM_RULES))
    else $error("rule count beyond capacity");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rule_open |-> (cur_count != '0 && cur_count <= CW'(MAX_POINTS)))
    else $error("open rule point count out of range");

  a_div_query: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> kind_q == swpt_pkg::KIND_QUERY)
    else $error("remainder unit busy outside a query");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && res_valid) |-> res_ready)
    else $error("result overwritten while stalled");

endmodule

FILE: rtl/core/swpt_ctrl.sv
// ----------------------------------------------------------------------------
// swpt_ctrl
// Controller: sequences one request at a time through decode, add, query
// (modulo then scan) or change check, then hands the result out.
// ----------------------------------------------------------------------------
module swpt_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  swpt_pkg::flags_t flags,
  output swpt_pkg::cmd_t   cmd
);

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_DECODE    = 9'b000000010,
    S_ADD_EXEC  = 9'b000000100,
    S_ADD_CLOSE = 9'b000001000,
    S_Q_START   = 9'b000010000,
    S_Q_DIV     = 9'b000100000,
    S_Q_SCAN    = 9'b001000000,
    S_CHECK     = 9'b010000000,
    S_FINISH    = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.classify = 1'b1;
        priority if (flags.early) begin
          state_next = S_FINISH;
        end else if (flags.kind == swpt_pkg::KIND_ADD) begin
          state_next = S_ADD_EXEC;
        end else if (flags.kind == swpt_pkg::KIND_QUERY) begin
          state_next = S_Q_START;
        end else begin
          state_next = S_CHECK;
        end
      end
      S_ADD_EXEC: begin
        cmd.add_exec = 1'b1;
        state_next   = flags.last ? S_ADD_CLOSE : S_FINISH;
      end
      S_ADD_CLOSE: begin
        cmd.add_close = 1'b1;
        state_next    = S_FINISH;
      end
      S_Q_START: begin
        cmd.div_start = 1'b1;
        state_next    = S_Q_DIV;
      end
      S_Q_DIV: begin
        if (!flags.div_busy) begin
          cmd.scan_init = 1'b1;
          state_next    = S_Q_SCAN;
        end
      end
      S_Q_SCAN: begin
        cmd.scan_step = 1'b1;
        if (flags.scan_done) begin
          cmd.scan_fin = 1'b1;
          state_next   = S_FINISH;
        end
      end
      S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (flags.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/step_waveform_pattern_table.sv
// ----------------------------------------------------------------------------
// step_waveform_pattern_table
// Table of periodic step waveforms for simulated sensors.
// ----------------------------------------------------------------------------
// Usage:
//   request: valid/ready channel carrying kind, rule_id, seconds, sample and
//     last_point. Add-point requests build rules numbered from 1; a request
//     with last_point set closes the rule. Query requests return the rule's
//     value at seconds modulo its period; check requests compare sample with
//     the rule's remembered value and update it.
//   result: valid/ready channel, one result per request.
// Steps from accept to result valid:
//   add point: decode, store the point, then close the rule when it is the
//   last; check: decode, compare; rejected: decode only; query: decode, the
//   bit-serial remainder unit (31 steps), then a scan with one point-memory
//   read per cycle. One request is in work at a time; the next is taken
//   in the cycle after the previous result reaches the output register.
// Reset: synchronous; clears the rule count, the open flag and all
//   remembered values (they read as minus one). No clearing pass is needed.
// Stall: the result register holds while ready is low; a following request
//   is still accepted and worked on, then waits until the register is free.
// ----------------------------------------------------------------------------
module step_waveform_pattern_table #(
  parameter int NUM_RULES  = swpt_pkg::NUM_RULES_DEF,
  parameter int MAX_POINTS = swpt_pkg::MAX_POINTS_DEF,
  parameter int VALUE_BITS = swpt_pkg::VALUE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  swpt_req_if.sink   request,
  swpt_rsp_if.source result
);

  swpt_pkg::cmd_t   cmd;
  swpt_pkg::flags_t flags;

  // sequencing
  swpt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (request.valid),
    .req_ready (request.ready),
    .flags     (flags),
    .cmd       (cmd)
  );

  // storage and arithmetic
  swpt_dp #(
    .NUM_RULES  (NUM_RULES),
    .MAX_POINTS (MAX_POINTS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .flags        (flags),
    .kind         (request.kind),
    .rule_id      (request.rule_id),
    .seconds      (request.seconds),
    .sample       (request.sample),
    .last_point   (request.last_point),
    .result_value (result.result_value),
    .rule_number  (result.rule_number),
    .changed      (result.changed),
    .status       (result.status),
    .res_valid    (result.valid),
    .res_ready    (result.ready)
  );

endmodule

FILE: verif/step_waveform_pattern_table_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// step_waveform_pattern_table_test
// Self-checking bench for the step waveform pattern table. A directed table
// covers the empty table, unknown rules, full rules, out-of-order point times
// and the time-zero overwrite. Random rule builds, queries and change checks
// follow. Every result is compared against a cycle-free model of the table,
// with random idle time on both the request and the result side.
// ----------------------------------------------------------------------------
module step_waveform_pattern_table_test;
  import swpt_pkg::*;

  localparam int NUM_RULES    = NUM_RULES_DEF;
  localparam int MAX_POINTS   = MAX_POINTS_DEF;
  localparam int RANDOM_ITEMS = 1950;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int DRAIN_CYCLES = 80;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AFTER   = 300;
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]          kind;
    logic [ID_W-1:0]            rule_id;
    logic [SECS_W-1:0]          seconds;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_point;
  } request_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic [ID_W-1:0]            rule;
    logic                       changed;
    logic [STATUS_W-1:0]        status;
  } outcome_t;

  typedef struct packed {
    request_t   q;
    logic [4:0] reps;
    logic       typed;
    outcome_t   want;
  } stim_row_t;

  localparam outcome_t UNTYPED = '0;

  logic clk = 1'b0;
  logic rst = 1'b1;

  swpt_req_if req_bus ();
  swpt_rsp_if rsp_bus ();

  step_waveform_pattern_table dut (
    .clk     (clk),
    .rst     (rst),
    .request (req_bus),
    .result  (rsp_bus)
  );

  always #10 clk = ~clk;

  // model state of the table
  logic [SECS_W-1:0]   pt_time   [NUM_RULES*MAX_POINTS];
  logic [SAMPLE_W-1:0] pt_value  [NUM_RULES*MAX_POINTS];
  int unsigned         pt_count  [NUM_RULES];
  logic [PERIOD_W-1:0] period    [NUM_RULES];
  logic [SAMPLE_W-1:0] remembered [NUM_RULES];
  int unsigned         rules_begun;
  bit                  building;

  outcome_t  awaited_outcomes [$];
  stim_row_t stim_plan [$];

  int unsigned mismatches    = 0;
  int unsigned results_taken = 0;
  int unsigned useful_sent   = 0;
  int unsigned n_adds = 0, n_add_full = 0, n_queries = 0, n_checks = 0, n_missing = 0;
  int unsigned cycles = 0;
  bit          send_quiet = 1'b0;
  bit          take_quiet = 1'b0;
  outcome_t    got, want;

  function automatic request_t mk_req(logic [KIND_W-1:0] kind, logic [ID_W-1:0] id,
                                      logic [SECS_W-1:0] secs, logic [SAMPLE_W-1:0] smp,
                                      logic last);
    mk_req = '{kind, id, secs, smp, last};
  endfunction

  function automatic outcome_t mk_out(logic [SAMPLE_W-1:0] v, logic [ID_W-1:0] rule,
                                      logic ch, logic [STATUS_W-1:0] st);
    mk_out = '{v, rule, ch, st};
  endfunction

  // one step of the table: updates the model state and returns the result
  function automatic outcome_t waveform_outcome(request_t q);
    outcome_t            o;
    int unsigned         r, base, n, closed;
    logic [PERIOD_W-1:0] t;
    logic [SAMPLE_W-1:0] v;
    o = '0;
    closed = rules_begun - (building ? 1 : 0);
    case (q.kind)
      KIND_ADD: begin
        if (!building && rules_begun >= NUM_RULES) begin
          o.status = ST_FULL;
        end else begin
          // first point opens a rule with an implicit point at time zero
          if (!building) begin
            r = rules_begun;
            pt_time[r*MAX_POINTS]  = '0;
            pt_value[r*MAX_POINTS] = '1;
            pt_count[r] = 1;
            period[r]   = 1;
            rules_begun++;
            building = 1'b1;
          end
          r = rules_begun - 1;
          base = r * MAX_POINTS;
          o.rule = ID_W'(r + 1);
          if (q.seconds == '0) begin
            pt_value[base] = q.sample;
            period[r] = 1;
          end else if (pt_count[r] >= MAX_POINTS) begin
            o.status = ST_FULL;
          end else begin
            pt_time[base + pt_count[r]]  = q.seconds;
            pt_value[base + pt_count[r]] = q.sample;
            pt_count[r]++;
            pt_value[base] = q.sample;
            period[r] = {1'b0, q.seconds} + 1;
          end
          if (q.last_point) building = 1'b0;
        end
      end
      KIND_QUERY: begin
        if (q.rule_id == 0 || q.rule_id > closed) begin
          o.value  = -1;
          o.status = ST_NOT_FOUND;
        end else begin
          // reduce time by the period, then walk points in stored order
          r = q.rule_id - 1;
          base = r * MAX_POINTS;
          n = pt_count[r];
          t = {1'b0, q.seconds} % period[r];
          v = pt_value[base];
          for (int i = 0; i < n; i++) begin
            if ({1'b0, pt_time[base + i]} > t) break;
            v = pt_value[base + i];
          end
          o.value = v;
          o.rule  = q.rule_id;
        end
      end
      KIND_CHECK: begin
        if (rules_begun == 0) begin
          o.changed = 1'b1;
        end else if (q.rule_id == 0 || q.rule_id > closed) begin
          o.value  = -1;
          o.status = ST_NOT_FOUND;
        end else begin
          r = q.rule_id - 1;
          o.rule = q.rule_id;
          if (remembered[r] != q.sample) begin
            remembered[r] = q.sample;
            o.changed = 1'b1;
          end
        end
      end
      default: begin
        // spare kind leaves everything untouched
      end
    endcase
    return o;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int unsigned idle_span(bit quiet);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // offer one request, wait for acceptance, then queue its expected result
  task automatic send_request(request_t q, bit typed, outcome_t fixed);
    int unsigned gap;
    outcome_t    o;
    if ($urandom_range(0, 59) == 0) send_quiet = !send_quiet;
    gap = idle_span(send_quiet);
    if (gap != 0) begin
      req_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_bus.kind       = q.kind;
    req_bus.rule_id    = q.rule_id;
    req_bus.seconds    = q.seconds;
    req_bus.sample     = q.sample;
    req_bus.last_point = q.last_point;
    req_bus.valid      = 1'b1;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    o = waveform_outcome(q);
    awaited_outcomes.push_back(typed ? fixed : o);
    if (q.kind != KIND_SPARE) useful_sent++;
    if (q.kind == KIND_ADD) begin
      n_adds++;
      if (o.status == ST_FULL) n_add_full++;
    end
    if (q.kind == KIND_QUERY) n_queries++;
    if (q.kind == KIND_CHECK) n_checks++;
    if (o.status == ST_NOT_FOUND) n_missing++;
    @(negedge clk);
  endtask

  // stop offering until every outstanding result is back
  task automatic drain_results();
    req_bus.valid = 1'b0;
    while (awaited_outcomes.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // query or change check, mostly on a closed rule
  task automatic probe_rule(logic [KIND_W-1:0] kind);
    request_t    q;
    int unsigned closed, lim, r;
    closed = rules_begun - (building ? 1 : 0);
    q = '0;
    q.kind = kind;
    q.last_point = 1'($urandom_range(0, 1));
    if (closed != 0 && $urandom_range(0, 99) < 85) begin
      q.rule_id = ID_W'($urandom_range(1, closed));
    end else begin
      q.rule_id = ID_W'($urandom_range(0, 15));
    end
    q.seconds = SECS_W'($urandom);
    q.sample  = $urandom;
    if (q.rule_id != 0 && q.rule_id <= closed) begin
      r = q.rule_id - 1;
      lim = (period[r] > 2000) ? 6000 : period[r] * 3;
      case ($urandom_range(0, 4))
        0, 1: q.seconds = SECS_W'($urandom_range(0, lim));
        2:    q.seconds = SECS_W'(period[r] - 1);
        default: ;
      endcase
      case ($urandom_range(0, 3))
        0, 1: q.sample = remembered[r];
        2:    q.sample = $urandom_range(0, 1) ? -1 : 0;
        default: ;
      endcase
    end
    send_request(q, 1'b0, UNTYPED);
  endtask

  // a run of add-point requests ending with the closing flag
  task automatic build_rule();
    request_t          q;
    int unsigned       npts;
    logic [SECS_W-1:0] t;
    npts = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 19) : $urandom_range(1, 6);
    t = '0;
    for (int i = 0; i < npts; i++) begin
      q.kind    = KIND_ADD;
      q.rule_id = ID_W'($urandom_range(0, 15));
      q.sample  = $urandom;
      case ($urandom_range(0, 9))
        0: q.seconds = '0;
        1: q.seconds = SECS_W'($urandom);
        default: begin
          t = t + SECS_W'($urandom_range(1, 40));
          q.seconds = t;
        end
      endcase
      q.last_point = (i == npts - 1);
      send_request(q, 1'b0, UNTYPED);
      // now and then probe a rule while this one is being built
      if ($urandom_range(0, 5) == 0) probe_rule($urandom_range(0, 1) ? KIND_QUERY : KIND_CHECK);
    end
  endtask

  // result side: random ready with one long hold-off
  initial begin
    int unsigned span;
    bit          held;
    held = 1'b0;
    rsp_bus.ready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (!held && results_taken >= HOLD_AFTER) begin
        held = 1'b1;
        rsp_bus.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if ($urandom_range(0, 59) == 0) take_quiet = !take_quiet;
      span = idle_span(take_quiet);
      if (span != 0) begin
        rsp_bus.ready = 1'b0;
        repeat (span) @(negedge clk);
      end
      rsp_bus.ready = 1'b1;
      @(negedge clk);
    end
  end

  // compare each result with the oldest expectation
  always @(posedge clk) begin
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      results_taken++;
      got = '{rsp_bus.result_value, rsp_bus.rule_number, rsp_bus.changed, rsp_bus.status};
      if (awaited_outcomes.size() == 0) begin
        $error("result with nothing outstanding: value %0d rule %0d", got.value, got.rule);
        mismatches++;
      end else begin
        want = awaited_outcomes.pop_front();
        if (got.value !== want.value) begin
          $error("result_value: expected %0d, actual %0d", want.value, got.value);
          mismatches++;
        end
        if (got.rule !== want.rule) begin
          $error("rule_number: expected %0d, actual %0d", want.rule, got.rule);
          mismatches++;
        end
        if (got.changed !== want.changed) begin
          $error("changed: expected %0d, actual %0d", want.changed, got.changed);
          mismatches++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, got.status);
          mismatches++;
        end
      end
    end
  end

  // watchdog
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("step_waveform_pattern_table: mismatch");
    $finish;
  end

  // reset, directed table, random traffic, drain
  initial begin
    request_t    q;
    int unsigned roll, directed_useful;
    bit          paused;
    paused = 1'b0;
    req_bus.valid      = 1'b0;
    req_bus.kind       = KIND_ADD;
    req_bus.rule_id    = '0;
    req_bus.seconds    = '0;
    req_bus.sample     = '0;
    req_bus.last_point = 1'b0;
    for (int i = 0; i < NUM_RULES; i++) remembered[i] = '1;
    foreach (pt_count[i]) pt_count[i] = 0;
    rules_begun = 0;
    building    = 1'b0;

    // empty table, unknown rules, spare kind
    stim_plan.push_back('{mk_req(KIND_CHECK, 4'd3, '0, 32'sd5, 1'b0), 5'd1, 1'b1,
                          mk_out(0, 4'd0, 1'b1, ST_DONE)});
    stim_plan.push_back('{mk_req(KIND_QUERY, 4'd1, 31'd100, 0, 1'b0), 5'd1, 1'b1,
                          mk_out(-1, 4'd0, 1'b0, ST_NOT_FOUND)});
    stim_plan.push_back('{mk_req(KIND_SPARE, 4'd15, '1, -1, 1'b1), 5'd1, 1'b1,
                          mk_out(0, 4'd0, 1'b0, ST_DONE)});
    // rule 1: time-zero overwrite, largest time, out-of-order point
    stim_plan.push_back('{mk_req(KIND_ADD, 4'd0, '0, 32'sh7FFF_FFFF, 1'b0), 5'd1, 1'b1,
                          mk_out(0, 4'd1, 1'b0, ST_DONE)});
    stim_plan.push_back('{mk_req(KIND_QUERY, 4'd1, 31'd0, 0, 1'b0), 5'd1, 1'b1,
                          mk_out(-1, 4'd0, 1'b0, ST_NOT_FOUND)});
    stim_plan.push_back('{mk_req(KIND_CHECK, 4'd1, 31'd0, 0, 1'b0), 5'd1, 1'b1,
                          mk_out(-1, 4'd0, 1'b0, ST_NOT_FOUND)});
    stim_plan.push_back('{mk_req(KIND_ADD, 4'd0, '1, 32'sh8000_0000, 1'b0), 5'd1, 1'b1,
                          mk_out(0, 4'd1, 1'b0, ST_DONE)});
    stim_plan.push_back('{mk_req(KIND_ADD, 4'd0, 31'd5, 32'sd42, 1'b1), 5'd1, 1'b1,
                          mk_out(0, 4'd1, 1'b0, ST_DONE)});
    stim_plan.push_back('{mk_req(KIND_QUERY, 4'd1, 31'd3, 0, 1'b0), 5'd1, 1'b0, UNTYPED});
    stim_plan.push_back('{mk_req(KIND_QUERY, 4'd1, '1, 0, 1'b0), 5'd1, 1'b0, UNTYPED});
    stim_plan.push_back('{mk_req(KIND_QUERY, 4'd1, '0, 0, 1'b0), 5'd1, 1'b0, UNTYPED});
    // remembered value starts at minus one
    stim_plan.push_back('{mk_req(KIND_CHECK, 4'd1, '0, -1, 1'b0), 5'd1, 1'b1,
                          mk_out(0, 4'd1, 1'b0, ST_DONE)});
    stim_plan.push_back('{mk_req(KIND_CHECK, 4'd1, '0, 0, 1'b0), 5'd1, 1'b1,
                          mk_out(0, 4'd1, 1'b1, ST_DONE)});
    stim_plan.push_back('{mk_req(KIND_CHECK, 4'd1, '0, 0, 1'b0), 5'd1, 1'b1,
                          mk_out(0, 4'd1, 1'b0, ST_DONE)});
    stim_plan.push_back('{mk_req(KIND_CHECK, 4'd0, '0, 0, 1'b0), 5'd1, 1'b1,
                          mk_out(-1, 4'd0, 1'b0, ST_NOT_FOUND)});
    stim_plan.push_back('{mk_req(KIND_QUERY, 4'd15, '0, 0, 1'b0), 5'd1, 1'b1,
                          mk_out(-1, 4'd0, 1'b0, ST_NOT_FOUND)});
    // rule 2: single point, period one
    stim_plan.push_back('{mk_req(KIND_ADD, 4'd0, '0, 32'sd7, 1'b1), 5'd1, 1'b1,
                          mk_out(0, 4'd2, 1'b0, ST_DONE)});
    stim_plan.push_back('{mk_req(KIND_QUERY, 4'd2, 31'd1234567, 0, 1'b0), 5'd1, 1'b1,
                          mk_out(7, 4'd2, 1'b0, ST_DONE)});
    // rule 3: fill to capacity, then a dropped point that still closes it
    stim_plan.push_back('{mk_req(KIND_ADD, 4'd0, 31'd10, 32'sd100, 1'b0), 5'd15, 1'b0,
                          UNTYPED});
    stim_plan.push_back('{mk_req(KIND_ADD, 4'd0, 31'd1000, 32'sd9, 1'b1), 5'd1, 1'b1,
                          mk_out(0, 4'd3, 1'b0, ST_FULL)});
    stim_plan.push_back('{mk_req(KIND_QUERY, 4'd3, 31'd155, 0, 1'b0), 5'd1, 1'b0, UNTYPED});
    stim_plan.push_back('{mk_req(KIND_QUERY, 4'd3, 31'd99999, 0, 1'b0), 5'd1, 1'b0,
                          UNTYPED});
    // rule 4: a time-zero point after an appended one resets the period
    stim_plan.push_back('{mk_req(KIND_ADD, 4'd0, '0, -5, 1'b0), 5'd1, 1'b1,
                          mk_out(0, 4'd4, 1'b0, ST_DONE)});
    stim_plan.push_back('{mk_req(KIND_ADD, 4'd0, 31'd30, 32'sd9, 1'b0), 5'd1, 1'b0, UNTYPED});
    stim_plan.push_back('{mk_req(KIND_ADD, 4'd0, '0, 32'sd3, 1'b1), 5'd1, 1'b0, UNTYPED});
    stim_plan.push_back('{mk_req(KIND_QUERY, 4'd4, 31'd77, 0, 1'b0), 5'd1, 1'b0, UNTYPED});

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table; repeated rows step time by 10 and value by 1
    foreach (stim_plan[i]) begin
      for (int j = 0; j < stim_plan[i].reps; j++) begin
        q = stim_plan[i].q;
        q.seconds = q.seconds + SECS_W'(10 * j);
        q.sample  = q.sample + j;
        send_request(q, stim_plan[i].typed, stim_plan[i].want);
      end
    end
    drain_results();
    directed_useful = useful_sent;

    // random traffic: rule builds, queries, checks and noise
    while (useful_sent < directed_useful + RANDOM_ITEMS) begin
      if (!paused && useful_sent >= directed_useful + RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        drain_results();
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        if (rules_begun < NUM_RULES || building) build_rule();
        else send_request(mk_req(KIND_ADD, ID_W'($urandom_range(0, 15)), SECS_W'($urandom),
                                 $urandom, 1'($urandom_range(0, 1))), 1'b0, UNTYPED);
      end else if (roll < 5) begin
        send_request(mk_req(KIND_SPARE, ID_W'($urandom_range(0, 15)), SECS_W'($urandom),
                            $urandom, 1'($urandom_range(0, 1))), 1'b0, UNTYPED);
      end else if (roll < 55) begin
        probe_rule(KIND_QUERY);
      end else begin
        probe_rule(KIND_CHECK);
      end
    end
    req_bus.valid = 1'b0;

    while (awaited_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d adds (%0d refused as full), %0d queries, %0d change checks",
             n_adds, n_add_full, n_queries, n_checks);
    $display("%0d rules built, %0d unknown-rule results, %0d results in %0d cycles",
             rules_begun, n_missing, results_taken, cycles);
    if (mismatches == 0 && awaited_outcomes.size() == 0) begin
      $display("step_waveform_pattern_table: match");
    end else begin
      $display("step_waveform_pattern_table: mismatch");
    end
    $finish;
  end

endmodule

FILE: step_waveform_pattern_table.f
rtl/core/swpt_pkg.sv
rtl/core/swpt_if.sv
rtl/core/swpt_mod.sv
rtl/core/swpt_dp.sv
rtl/core/swpt_ctrl.sv
rtl/core/step_waveform_pattern_table.sv
verif/step_waveform_pattern_table_test.sv
